>>> rtl/cal_pkg.sv
`default_nettype none

package cal_pkg;

    localparam int CAL_MAX_OPS = 65535;

    localparam int OP_CODE_W  = 4;
    localparam int OP_LEN_W   = 28;
    localparam int READ_LEN_W = 31;
    localparam int SUM_W      = 48;
    localparam int ERR_W      = 2;

    // CIGAR opcodes; 9..15 are undefined
    typedef enum logic [OP_CODE_W-1:0] {
        OP_M  = 4'd0,
        OP_I  = 4'd1,
        OP_D  = 4'd2,
        OP_N  = 4'd3,
        OP_S  = 4'd4,
        OP_H  = 4'd5,
        OP_P  = 4'd6,
        OP_EQ = 4'd7,
        OP_X  = 4'd8
    } cal_op_t;

    typedef enum logic [1:0] {
        KIND_STOP    = 2'd0,
        KIND_CLIP    = 2'd1,
        KIND_SKIP    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } cal_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_UNKNOWN_OP = 2'd1,
        ERR_TOO_MANY   = 2'd2
    } cal_err_t;

    typedef struct packed {
        logic [OP_CODE_W-1:0]  op_code;
        logic [OP_LEN_W-1:0]   op_length;
        logic [READ_LEN_W-1:0] read_length;
        logic                  last_op;
    } cal_item_t;

    // per-record totals handed from the accumulator to the output stage
    typedef struct packed {
        logic [READ_LEN_W-1:0] read_length;
        logic [SUM_W-1:0]      head_sum;
        logic [SUM_W-1:0]      tail_sum;
        logic [SUM_W-1:0]      net_indel;   // deletions - insertions
        cal_err_t              err;
    } cal_totals_t;

endpackage

`default_nettype wire

>>> rtl/cal_in_if.sv
`default_nettype none

interface cal_in_if import cal_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_CODE_W-1:0]  op_code;
    logic [OP_LEN_W-1:0]   op_length;
    logic [READ_LEN_W-1:0] read_length;
    logic                  last_op;

    modport source (output valid, op_code, op_length, read_length, last_op, input ready);
    modport sink   (input valid, op_code, op_length, read_length, last_op, output ready);
endinterface

`default_nettype wire

>>> rtl/cal_out_if.sv
`default_nettype none

interface cal_out_if import cal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] aligned_length;
    logic [SUM_W-1:0]        start_clip;
    logic [SUM_W-1:0]        end_clip;
    logic [ERR_W-1:0]        error_code;

    modport source (output valid, aligned_length, start_clip, end_clip, error_code,
                    input ready);
    modport sink   (input valid, aligned_length, start_clip, end_clip, error_code,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/cal_accum.sv
`default_nettype none

module cal_accum import cal_pkg::*; #(
    parameter int MAX_OPS = CAL_MAX_OPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        boundary_at_match,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire cal_item_t   item,
    output logic             tot_valid,
    input  wire logic        tot_ready,
    output cal_totals_t      tot
);

    // holds 0..MAX_OPS+1 (saturating)
    localparam int IDX_W = $clog2(MAX_OPS + 2);

    logic [IDX_W-1:0] op_index_reg, op_index_next;
    logic             head_done_reg, head_done_next;
    logic [SUM_W-1:0] head_sum_reg, head_sum_next;
    logic             head_error_reg, head_error_next;
    logic [SUM_W-1:0] tail_sum_reg, tail_sum_next;
    logic             tail_error_reg, tail_error_next;
    logic [SUM_W-1:0] net_reg, net_next;
    logic             tot_valid_reg, tot_valid_next;
    cal_totals_t      tot_reg, tot_next;

    cal_kind_t        kind;
    logic             fire;
    logic             too_many;
    logic [SUM_W-1:0] len_ext;

    always_comb
    begin
        unique case (item.op_code) inside
            OP_M, OP_EQ, OP_X: kind = KIND_STOP;
            OP_I:              kind = boundary_at_match ? KIND_CLIP : KIND_STOP;
            OP_D, OP_N:        kind = boundary_at_match ? KIND_SKIP : KIND_STOP;
            OP_S:              kind = KIND_CLIP;
            OP_H, OP_P:        kind = KIND_SKIP;
            default:           kind = KIND_UNKNOWN;
        endcase
    end

    // a last beat needs the totals slot free
    assign item_ready = !item.last_op || !tot_valid_reg || tot_ready;
    assign fire       = item_valid && item_ready;
    assign len_ext    = SUM_W'(item.op_length);
    assign too_many   = op_index_reg >= IDX_W'(MAX_OPS);

    always_comb
    begin
        op_index_next   = op_index_reg;
        head_done_next  = head_done_reg;
        head_sum_next   = head_sum_reg;
        head_error_next = head_error_reg;
        tail_sum_next   = tail_sum_reg;
        tail_error_next = tail_error_reg;
        net_next        = net_reg;
        tot_valid_next  = tot_valid_reg && !tot_ready;
        tot_next        = tot_reg;

        if (fire)
        begin
            if (item.op_code == OP_I)
                net_next = net_reg - len_ext;
            else if (item.op_code == OP_D)
                net_next = net_reg + len_ext;

            if (!head_done_reg)
            begin
                if (kind == KIND_STOP)
                    head_done_next = 1'b1;
                else if (kind == KIND_CLIP)
                    head_sum_next = head_sum_reg + len_ext;
                else if (kind == KIND_UNKNOWN)
                    head_error_next = 1'b1;
            end

            // trailing region restarts at every stop; first op never trails
            if (kind == KIND_STOP)
            begin
                tail_sum_next   = '0;
                tail_error_next = 1'b0;
            end
            else if (op_index_reg != '0)
            begin
                if (kind == KIND_CLIP)
                    tail_sum_next = tail_sum_reg + len_ext;
                else if (kind == KIND_UNKNOWN)
                    tail_error_next = 1'b1;
            end

            if (op_index_reg <= IDX_W'(MAX_OPS))
                op_index_next = op_index_reg + 1'b1;

            if (item.last_op)
            begin
                tot_valid_next       = 1'b1;
                tot_next.read_length = item.read_length;
                tot_next.head_sum    = head_sum_next;
                tot_next.tail_sum    = tail_sum_next;
                tot_next.net_indel   = net_next;
                if (too_many)
                    tot_next.err = ERR_TOO_MANY;
                else if (head_error_next || tail_error_next)
                    tot_next.err = ERR_UNKNOWN_OP;
                else
                    tot_next.err = ERR_OK;

                op_index_next   = '0;
                head_done_next  = 1'b0;
                head_sum_next   = '0;
                head_error_next = 1'b0;
                tail_sum_next   = '0;
                tail_error_next = 1'b0;
                net_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_index_reg   <= '0;
            head_done_reg  <= 1'b0;
            head_sum_reg   <= '0;
            head_error_reg <= 1'b0;
            tail_sum_reg   <= '0;
            tail_error_reg <= 1'b0;
            net_reg        <= '0;
            tot_valid_reg  <= 1'b0;
        end
        else
        begin
            op_index_reg   <= op_index_next;
            head_done_reg  <= head_done_next;
            head_sum_reg   <= head_sum_next;
            head_error_reg <= head_error_next;
            tail_sum_reg   <= tail_sum_next;
            tail_error_reg <= tail_error_next;
            net_reg        <= net_next;
            tot_valid_reg  <= tot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg <= tot_next;
    end

    assign tot_valid = tot_valid_reg;
    assign tot       = tot_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last_op) |=> (op_index_reg == '0 && !head_done_reg
                                    && head_sum_reg == '0 && net_reg == '0))
        else $error("record state not cleared after last beat");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op_index_reg <= IDX_W'(MAX_OPS + 1))
        else $error("op index past saturation");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        tot_valid_reg |-> (tot_reg.err == ERR_OK || tot_reg.err == ERR_UNKNOWN_OP
                           || tot_reg.err == ERR_TOO_MANY))
        else $error("bad error code in totals");

endmodule

`default_nettype wire

>>> rtl/cigar_aligned_length_top.sv
`default_nettype none

// CIGAR aligned-length unit. Feed the CIGAR operations of one alignment
// record on op_in, one beat per operation, with last_op set on the final
// one; read_length is only looked at on that last beat. Each record gives
// one beat on len_out: aligned_length = read_length - start_clip - end_clip
// + deletions - insertions (48-bit two's complement, all sums wrap mod
// 2^48), the leading and trailing clip, and error_code (1: unknown opcode
// in a clip region, 2: more than MAX_OPS operations; 2 wins). Non-last
// beats produce nothing. boundary_at_match (reset 1) makes boundary I count
// as clip and boundary D/N be skipped; with it clear, I/D/N end the clip
// scan. Note that in boundary mode a boundary insertion is subtracted
// twice, once as clip and once as insertion. Write the register only
// while no record is in flight. Throughput is one operation per cycle,
// back to back, with full backpressure support. The last beat's result
// passes through the input register, the accumulator/totals register,
// then the final four-operand sum into the output register.
module cigar_aligned_length_top import cal_pkg::*; #(
    parameter int MAX_OPS = CAL_MAX_OPS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data,
    cal_in_if.sink     op_in,
    cal_out_if.source  len_out
);

    // config register
    logic boundary_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boundary_reg <= 1'b1;
        else if (cfg_wr_en)
            boundary_reg <= cfg_wr_data;
    end

    // stage 1: input register
    logic      in_valid_reg, in_valid_next;
    cal_item_t item_reg;
    logic      acc_ready;
    logic      in_fire;

    assign op_in.ready = !in_valid_reg || acc_ready;
    assign in_fire     = op_in.valid && op_in.ready;

    always_comb
    begin
        if (in_fire)
            in_valid_next = 1'b1;
        else if (acc_ready)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.op_code     <= op_in.op_code;
            item_reg.op_length   <= op_in.op_length;
            item_reg.read_length <= op_in.read_length;
            item_reg.last_op     <= op_in.last_op;
        end
    end

    // stage 2: per-record accumulation, totals register
    logic        tot_valid;
    logic        tot_ready;
    cal_totals_t tot;

    cal_accum #(
        .MAX_OPS (MAX_OPS)
    ) u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .boundary_at_match (boundary_reg),
        .item_valid        (in_valid_reg),
        .item_ready        (acc_ready),
        .item              (item_reg),
        .tot_valid         (tot_valid),
        .tot_ready         (tot_ready),
        .tot               (tot)
    );

    // stage 3: final sum into output register
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] aligned_reg, aligned_next;
    logic [SUM_W-1:0] start_clip_reg;
    logic [SUM_W-1:0] end_clip_reg;
    cal_err_t         err_reg;
    logic             tot_fire;

    assign tot_ready = !out_valid_reg || len_out.ready;
    assign tot_fire  = tot_valid && tot_ready;

    assign aligned_next = SUM_W'(tot.read_length) - tot.head_sum - tot.tail_sum
                        + tot.net_indel;

    always_comb
    begin
        if (tot_fire)
            out_valid_next = 1'b1;
        else if (len_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tot_fire)
        begin
            aligned_reg    <= aligned_next;
            start_clip_reg <= tot.head_sum;
            end_clip_reg   <= tot.tail_sum;
            err_reg        <= tot.err;
        end
    end

    assign len_out.valid          = out_valid_reg;
    assign len_out.aligned_length = $signed(aligned_reg);
    assign len_out.start_clip     = start_clip_reg;
    assign len_out.end_clip       = end_clip_reg;
    assign len_out.error_code     = err_reg;

    // a held input beat must not be dropped while the accumulator stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !acc_ready) |=> in_valid_reg)
        else $error("input stage lost a stalled beat");

    // a stalled result must not be overwritten by new totals
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !len_out.ready) |-> !tot_fire)
        else $error("output register overwritten while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !len_out.ready) |=> (out_valid_reg && $stable(aligned_reg)
                                               && $stable(err_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
